// ----- sv/msd_pkg.sv -----
`timescale 1ns / 1ps

package msd_pkg;

    localparam int NUM_SWITCHES_DEF = 8;
    localparam int WINDOW_LEN       = 5;

    localparam int SW_IDX_W    = 3;
    localparam int STATE_CODE_W = 2;
    localparam int TIME_W      = 16;
    localparam int MS_W        = 8;
    localparam int PRESCALE_W  = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_INIT = 1'b1;

    localparam logic [STATE_CODE_W-1:0] CODE_RELEASED     = 2'd0;
    localparam logic [STATE_CODE_W-1:0] CODE_PRE_PRESSED  = 2'd1;
    localparam logic [STATE_CODE_W-1:0] CODE_PRESSED      = 2'd2;
    localparam logic [STATE_CODE_W-1:0] CODE_PRE_RELEASED = 2'd3;

    // window masks, bit 0 oldest sample
    localparam logic [WINDOW_LEN-1:0] EDGE_MASK      = 5'b11011;
    localparam logic [WINDOW_LEN-1:0] RISE_PATTERN   = 5'b11000;
    localparam logic [WINDOW_LEN-1:0] FALL_PATTERN   = 5'b00011;
    localparam logic [WINDOW_LEN-1:0] NEWEST3_MASK   = 5'b11100;
    localparam logic [WINDOW_LEN-1:0] WIN_ALL        = 5'b11111;
    localparam logic [WINDOW_LEN-1:0] WIN_NONE       = 5'b00000;
    localparam logic [WINDOW_LEN-1:0] WIN_PRE_RELEASE = 5'b00111;

    typedef enum logic [3:0] {
        ST_RELEASED     = 4'b0001,
        ST_PRE_PRESSED  = 4'b0010,
        ST_PRESSED      = 4'b0100,
        ST_PRE_RELEASED = 4'b1000
    } key_state_t;

    function automatic logic [STATE_CODE_W-1:0] state_code(input key_state_t st);
        logic [STATE_CODE_W-1:0] c;
        case (st)
            ST_RELEASED:     c = CODE_RELEASED;
            ST_PRE_PRESSED:  c = CODE_PRE_PRESSED;
            ST_PRESSED:      c = CODE_PRESSED;
            ST_PRE_RELEASED: c = CODE_PRE_RELEASED;
            default:         c = CODE_RELEASED;
        endcase
        return c;
    endfunction

    function automatic key_state_t code_state(input logic [STATE_CODE_W-1:0] c);
        key_state_t st;
        case (c)
            CODE_RELEASED:     st = ST_RELEASED;
            CODE_PRE_PRESSED:  st = ST_PRE_PRESSED;
            CODE_PRESSED:      st = ST_PRESSED;
            CODE_PRE_RELEASED: st = ST_PRE_RELEASED;
            default:           st = ST_RELEASED;
        endcase
        return st;
    endfunction

    // pressed-sense pattern loaded by init
    function automatic logic [WINDOW_LEN-1:0] init_pattern(input logic [STATE_CODE_W-1:0] c);
        logic [WINDOW_LEN-1:0] p;
        case (c)
            CODE_RELEASED:     p = WIN_NONE;
            CODE_PRE_PRESSED:  p = RISE_PATTERN;
            CODE_PRESSED:      p = WIN_ALL;
            CODE_PRE_RELEASED: p = WIN_PRE_RELEASE;
            default:           p = WIN_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [TIME_W-1:0] grow_time(
        input logic [TIME_W-1:0] t,
        input logic [TIME_W-1:0] cap,
        input logic [MS_W-1:0]   period
    );
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W+1-MS_W){1'b0}}, period};
        if (t >= cap) begin
            return t;
        end else if (s[TIME_W]) begin
            return {TIME_W{1'b1}};
        end else begin
            return s[TIME_W-1:0];
        end
    endfunction

endpackage

// ----- sv/multi_switch_debounce_fsm.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake               | Payload
// s_      | in  | s_tvalid / s_tready     | s_tuser opcode; s_tdata switch, pin, init state
// m_      | out | m_tvalid / m_tready     | m_tuser sampled; m_tdata switch, state, times
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
// One word accepted per cycle while the input register is empty or its word can move on;
// each result reaches m_tdata through the input register and then the result register.
// The per-switch state is read and written in the same cycle as the word leaves the input
// register, so words for the same switch may follow back to back.
// Synchronous active-low reset returns all per-switch state, the configuration and the valid flags to defaults.
// A stalled result holds its own register; the input register still fills behind it.
// cfg_ready is always high.

module multi_switch_debounce_fsm
    import msd_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] switch_index, [3] pin_level, [5:4] init_state, [7:6] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] switch_index_out, [4:3] debounced_state, [20:5] press_time_ms,
    // [36:21] release_time_ms, [39:37] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] sampled
    output logic                  m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
    localparam int SEL_W = (IDX_W > SW_IDX_W) ? IDX_W : SW_IDX_W;
    localparam logic [WINDOW_LEN-1:0] WIN_RESET = WIN_ALL;

    // configuration
    logic [MS_W-1:0]   tick_len_reg;
    logic [MS_W-1:0]   period_reg;
    logic [TIME_W-1:0] press_cap_reg;
    logic [TIME_W-1:0] release_cap_reg;
    logic              pressed_lvl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_len_reg    <= MS_W'(1);
            period_reg      <= MS_W'(10);
            press_cap_reg   <= TIME_W'(60000);
            release_cap_reg <= TIME_W'(60000);
            pressed_lvl_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TICK_LENGTH:   tick_len_reg    <= cfg_data[MS_W-1:0];
                CFG_SAMPLE_PERIOD: period_reg      <= cfg_data[MS_W-1:0];
                CFG_PRESS_CAP:     press_cap_reg   <= cfg_data;
                CFG_RELEASE_CAP:   release_cap_reg <= cfg_data;
                CFG_PRESSED_LEVEL: pressed_lvl_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    logic                    in_valid_reg;
    logic                    in_op_reg;
    logic [SW_IDX_W-1:0]     in_idx_reg;
    logic                    in_pin_reg;
    logic [STATE_CODE_W-1:0] in_init_reg;

    logic out_valid_reg;
    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_idx_reg  <= s_tdata[2:0];
            in_pin_reg  <= s_tdata[3];
            in_init_reg <= s_tdata[5:4];
        end
    end

    // per-switch state
    key_state_t            fsm_reg      [NUM_SWITCHES];
    logic [WINDOW_LEN-1:0] win_reg      [NUM_SWITCHES];
    logic [TIME_W-1:0]     press_reg    [NUM_SWITCHES];
    logic [TIME_W-1:0]     release_reg  [NUM_SWITCHES];
    logic [PRESCALE_W-1:0] prescale_reg [NUM_SWITCHES];

    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
    logic             hit;

    assign sel = SEL_W'(in_idx_reg);
    assign idx = sel[IDX_W-1:0];
    assign hit = ({{(32-SW_IDX_W){1'b0}}, in_idx_reg} < 32'(NUM_SWITCHES));

    key_state_t            st_cur, st_next;
    logic [WINDOW_LEN-1:0] win_cur, win_next, pw;
    logic [TIME_W-1:0]     press_cur, press_next;
    logic [TIME_W-1:0]     release_cur, release_next;
    logic [PRESCALE_W-1:0] pre_cur, pre_next;
    logic [PRESCALE_W:0]   pre_sum;
    logic                  sampled;

    assign st_cur      = fsm_reg[idx];
    assign win_cur     = win_reg[idx];
    assign press_cur   = press_reg[idx];
    assign release_cur = release_reg[idx];
    assign pre_cur     = prescale_reg[idx];

    always_comb begin
        st_next      = st_cur;
        win_next     = win_cur;
        press_next   = press_cur;
        release_next = release_cur;
        pre_next     = pre_cur;
        sampled      = 1'b0;
        pw           = WIN_NONE;
        pre_sum      = {1'b0, pre_cur} + {{(PRESCALE_W+1-MS_W){1'b0}}, tick_len_reg};
        if (in_op_reg == OP_INIT) begin
            st_next      = code_state(in_init_reg);
            press_next   = '0;
            release_next = '0;
            win_next     = pressed_lvl_reg ? init_pattern(in_init_reg)
                                           : ~init_pattern(in_init_reg);
        end else if (pre_sum < {{(PRESCALE_W+1-MS_W){1'b0}}, period_reg}) begin
            pre_next = pre_sum[PRESCALE_W-1:0];
        end else begin
            pre_next = '0;
            sampled  = 1'b1;
            win_next = {in_pin_reg, win_cur[WINDOW_LEN-1:1]};
            pw       = pressed_lvl_reg ? win_next : ~win_next;
            case (st_cur)
                ST_RELEASED: begin
                    if ((pw & EDGE_MASK) == RISE_PATTERN) begin
                        st_next      = ST_PRE_PRESSED;
                        release_next = '0;
                    end else begin
                        release_next = grow_time(release_cur, release_cap_reg, period_reg);
                    end
                end
                ST_PRE_PRESSED: begin
                    if ((pw & NEWEST3_MASK) == NEWEST3_MASK) begin
                        st_next    = ST_PRESSED;
                        press_next = '0;
                    end
                end
                ST_PRESSED: begin
                    if ((pw & EDGE_MASK) == FALL_PATTERN) begin
                        st_next    = ST_PRE_RELEASED;
                        press_next = '0;
                    end else begin
                        press_next = grow_time(press_cur, press_cap_reg, period_reg);
                    end
                end
                default: begin
                    if ((pw & NEWEST3_MASK) == WIN_NONE) begin
                        st_next      = ST_RELEASED;
                        release_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                fsm_reg[i]      <= ST_RELEASED;
                win_reg[i]      <= WIN_RESET;
                press_reg[i]    <= '0;
                release_reg[i]  <= '0;
                prescale_reg[i] <= '0;
            end
        end else if (fire && hit) begin
            fsm_reg[idx]      <= st_next;
            win_reg[idx]      <= win_next;
            press_reg[idx]    <= press_next;
            release_reg[idx]  <= release_next;
            prescale_reg[idx] <= pre_next;
        end
    end

    // result register
    logic [SW_IDX_W-1:0]     out_idx_reg;
    logic [STATE_CODE_W-1:0] out_state_reg;
    logic [TIME_W-1:0]       out_press_reg;
    logic [TIME_W-1:0]       out_release_reg;
    logic                    out_sampled_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_idx_reg     <= in_idx_reg;
            out_state_reg   <= hit ? state_code(st_next) : CODE_RELEASED;
            out_press_reg   <= hit ? press_next : '0;
            out_release_reg <= hit ? release_next : '0;
            out_sampled_reg <= hit && sampled;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_sampled_reg;
    assign m_tdata  = {3'b000, out_release_reg, out_press_reg, out_state_reg, out_idx_reg};

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import msd_pkg::*;

    localparam int NSW = NUM_SWITCHES_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic                    op;
        logic [SW_IDX_W-1:0]     sw;
        logic                    pin;
        logic [STATE_CODE_W-1:0] ist;
    } switch_word_t;

    typedef struct packed {
        logic [SW_IDX_W-1:0]     sw;
        logic [STATE_CODE_W-1:0] state;
        logic [TIME_W-1:0]       press_ms;
        logic [TIME_W-1:0]       release_ms;
        logic                    sampled;
    } switch_status_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor registers and per-switch state
    logic [MS_W-1:0]         tick_ms;
    logic [MS_W-1:0]         period_ms;
    logic [TIME_W-1:0]       press_cap;
    logic [TIME_W-1:0]       release_cap;
    logic                    pressed_level;
    logic [STATE_CODE_W-1:0] fsm_code [NSW];
    logic [WINDOW_LEN-1:0]   window [NSW];
    logic [TIME_W-1:0]       press_time [NSW];
    logic [TIME_W-1:0]       release_time [NSW];
    logic [PRESCALE_W-1:0]   prescale [NSW];

    switch_word_t   pending_words [$];
    switch_status_t expected_status [$];
    switch_word_t   cur_word;
    switch_status_t exp_status;
    logic           drive_level [NSW];
    int             drv_gap = 0;
    int             drv_burst = 0;
    int             mon_stall = 0;
    int             mon_burst = 0;
    int             err_cnt = 0;

    multi_switch_debounce_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [TIME_W-1:0] grow_ms(input logic [TIME_W-1:0] t,
                                                  input logic [TIME_W-1:0] cap);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + {{(TIME_W+1-MS_W){1'b0}}, period_ms};
        if (t >= cap) begin
            return t;
        end
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    function automatic switch_status_t debounce_step(input switch_word_t w);
        switch_status_t        r;
        logic [WINDOW_LEN-1:0] pw;
        logic [PRESCALE_W:0]   acc;
        r.sampled = 1'b0;
        if (w.op == OP_INIT) begin
            fsm_code[w.sw]     = w.ist;
            press_time[w.sw]   = '0;
            release_time[w.sw] = '0;
            case (w.ist)
                CODE_RELEASED:    pw = 5'b00000;
                CODE_PRE_PRESSED: pw = 5'b11000;
                CODE_PRESSED:     pw = 5'b11111;
                default:          pw = 5'b00111;
            endcase
            window[w.sw] = pressed_level ? pw : ~pw;
        end else begin
            acc = {1'b0, prescale[w.sw]} + {{(PRESCALE_W+1-MS_W){1'b0}}, tick_ms};
            if (acc < {{(PRESCALE_W+1-MS_W){1'b0}}, period_ms}) begin
                prescale[w.sw] = acc[PRESCALE_W-1:0];
            end else begin
                prescale[w.sw] = '0;
                window[w.sw]   = {w.pin, window[w.sw][WINDOW_LEN-1:1]};
                pw = pressed_level ? window[w.sw] : ~window[w.sw];
                // pw bit set = sample reads as pressed; bit 0 oldest
                case (fsm_code[w.sw])
                    CODE_RELEASED: begin
                        if ((pw & 5'b11011) == 5'b11000) begin
                            fsm_code[w.sw]     = CODE_PRE_PRESSED;
                            release_time[w.sw] = '0;
                        end else begin
                            release_time[w.sw] = grow_ms(release_time[w.sw], release_cap);
                        end
                    end
                    CODE_PRE_PRESSED: begin
                        if ((pw & 5'b11100) == 5'b11100) begin
                            fsm_code[w.sw]   = CODE_PRESSED;
                            press_time[w.sw] = '0;
                        end
                    end
                    CODE_PRESSED: begin
                        if ((pw & 5'b11011) == 5'b00011) begin
                            fsm_code[w.sw]   = CODE_PRE_RELEASED;
                            press_time[w.sw] = '0;
                        end else begin
                            press_time[w.sw] = grow_ms(press_time[w.sw], press_cap);
                        end
                    end
                    default: begin
                        if ((pw & 5'b11100) == 5'b00000) begin
                            fsm_code[w.sw]     = CODE_RELEASED;
                            release_time[w.sw] = '0;
                        end
                    end
                endcase
                r.sampled = 1'b1;
            end
        end
        r.sw         = w.sw;
        r.state      = fsm_code[w.sw];
        r.press_ms   = press_time[w.sw];
        r.release_ms = release_time[w.sw];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                               input logic [TIME_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status.push_back(debounce_step(cur_word));
                if (drv_burst > 0) begin
                    drv_burst--;
                    drv_gap = 0;
                end else begin
                    drv_gap = $urandom_range(0, 4);
                    if ($urandom_range(0, 15) == 0) drv_burst = $urandom_range(8, 32);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_word.ist, cur_word.pin, cur_word.sw};
                    s_tuser  <= cur_word.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    $error("result word with no expectation pending");
                    err_cnt++;
                end else begin
                    exp_status = expected_status.pop_front();
                    check_field("switch_index_out", TIME_W'(exp_status.sw),
                                TIME_W'(m_tdata[2:0]));
                    check_field("debounced_state", TIME_W'(exp_status.state),
                                TIME_W'(m_tdata[4:3]));
                    check_field("press_time_ms", exp_status.press_ms, m_tdata[20:5]);
                    check_field("release_time_ms", exp_status.release_ms, m_tdata[36:21]);
                    check_field("sampled", TIME_W'(exp_status.sampled), TIME_W'(m_tuser));
                end
                if (mon_burst > 0) begin
                    mon_burst--;
                    mon_stall = 0;
                end else begin
                    mon_stall = $urandom_range(0, 4);
                    if ($urandom_range(0, 15) == 0) mon_burst = $urandom_range(8, 32);
                end
            end
            if (mon_stall > 0) begin
                mon_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic model_reset();
        tick_ms       = 8'd1;
        period_ms     = 8'd10;
        press_cap     = 16'd60000;
        release_cap   = 16'd60000;
        pressed_level = 1'b0;
        for (int i = 0; i < NSW; i++) begin
            fsm_code[i]     = CODE_RELEASED;
            window[i]       = {WINDOW_LEN{1'b1}};
            press_time[i]   = '0;
            release_time[i] = '0;
            prescale[i]     = '0;
            drive_level[i]  = 1'b1;
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_status.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    // call at a rising edge; leaves cfg_valid high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_TICK_LENGTH:   tick_ms       = data[MS_W-1:0];
            CFG_SAMPLE_PERIOD: period_ms     = data[MS_W-1:0];
            CFG_PRESS_CAP:     press_cap     = data;
            CFG_RELEASE_CAP:   release_cap   = data;
            CFG_PRESSED_LEVEL: pressed_level = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] tick, input logic [CFG_DATA_W-1:0] period,
                             input logic [CFG_DATA_W-1:0] pcap, input logic [CFG_DATA_W-1:0] rcap,
                             input logic [CFG_DATA_W-1:0] lvl);
        wait_idle();
        @(posedge aclk);
        write_reg(CFG_TICK_LENGTH, tick);
        write_reg(CFG_SAMPLE_PERIOD, period);
        write_reg(CFG_PRESS_CAP, pcap);
        write_reg(CFG_RELEASE_CAP, rcap);
        write_reg(CFG_PRESSED_LEVEL, lvl);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic push_word(input logic op, input int sw, input logic pin, input int ist);
        switch_word_t w;
        w.op  = op;
        w.sw  = sw[SW_IDX_W-1:0];
        w.pin = pin;
        w.ist = ist[STATE_CODE_W-1:0];
        pending_words.push_back(w);
    endtask

    // level runs per switch with occasional glitches and inits
    task automatic add_random(input int n, input int sw_hi, input int flip_odds);
        int  sw;
        logic pin;
        repeat (n) begin
            sw = $urandom_range(0, sw_hi);
            if ($urandom_range(0, flip_odds - 1) == 0) drive_level[sw] = ~drive_level[sw];
            pin = drive_level[sw] ^ ($urandom_range(0, 9) == 0);
            push_word(($urandom_range(0, 29) == 0) ? OP_INIT : OP_TICK, sw, pin,
                      $urandom_range(0, 3));
        end
    endtask

    initial begin
        model_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: ticks too short to sample
        push_word(OP_TICK, 0, 1'b1, 0);
        push_word(OP_TICK, 7, 1'b0, 3);

        // every tick samples, press cap at max, release cap zero, active-high
        configure(16'd10, 16'd10, 16'd65535, 16'd0, 16'd1);
        push_word(OP_INIT, 1, 1'b1, int'(CODE_RELEASED));
        push_word(OP_INIT, 1, 1'b0, int'(CODE_PRE_PRESSED));
        push_word(OP_INIT, 1, 1'b1, int'(CODE_PRESSED));
        push_word(OP_INIT, 1, 1'b0, int'(CODE_PRE_RELEASED));
        push_word(OP_TICK, 1, 1'b0, 0);
        push_word(OP_TICK, 6, 1'b1, 0);
        push_word(OP_TICK, 6, 1'b1, 1);
        push_word(OP_TICK, 6, 1'b1, 2);
        push_word(OP_TICK, 6, 1'b1, 3);
        push_word(OP_TICK, 6, 1'b1, 0);
        push_word(OP_TICK, 6, 1'b1, 0);
        push_word(OP_TICK, 6, 1'b0, 0);
        push_word(OP_TICK, 6, 1'b0, 0);
        push_word(OP_TICK, 6, 1'b0, 0);
        push_word(OP_TICK, 6, 1'b0, 0);

        configure(16'd1, 16'd1, 16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                  16'd0);
        add_random(240, 7, 8);

        // long hold drives press time into saturation
        configure(16'd255, 16'd254, 16'd65535, 16'd65535, 16'd1);
        push_word(OP_INIT, 5, 1'b0, int'(CODE_PRESSED));
        repeat (262) push_word(OP_TICK, 5, 1'b1, $urandom_range(0, 3));
        add_random(100, 7, 6);

        // zero period: acts on every tick, even with zero tick length
        configure(16'd0, 16'd0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 1)));
        @(posedge aclk);
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        @(negedge aclk);
        add_random(220, 7, 8);

        // zero tick length with nonzero period never acts
        configure(16'd0, 16'd5, 16'd60000, 16'd60000, 16'($urandom_range(0, 1)));
        add_random(120, 7, 8);

        // upper data bits of the 8-bit registers carry junk
        configure({8'($urandom_range(0, 255)), 8'($urandom_range(1, 20))},
                  {8'($urandom_range(0, 255)), 8'($urandom_range(1, 60))},
                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                  16'($urandom_range(0, 1)));
        add_random(260, 7, 5);

        configure(16'd255, 16'd255, 16'd1000, 16'd65535, 16'd0);
        add_random(240, 7, 6);

        wait_idle();
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
